FILE: sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam int unsigned NumChain  = 8;
  localparam int unsigned NumSched  = 16;
  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [NumChain] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Padding marker byte placed right after the last message byte
  localparam logic [7:0] PadMarker = 8'h80;
  // First byte position of the length field inside a block
  localparam logic [5:0] LenFieldPos = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with one shared round unit and a 16-word schedule window.
// ----------------------------------------------------------------------------
// Each request carries an optional message byte and an optional end mark.
// A byte request is taken while the unit is idle; every 64th byte starts a
// compression (64 rounds through the single round unit, then a fold of
// the working words into the chaining words), during which in_ready_o is low.
// An end mark adds one padding byte per cycle up to the end of the block
// (one or two compressions), then the digest leaves as four 64-bit words,
// word 0 most significant, one per cycle while out_ready_i is high. After the
// last word the hash state returns to the initial values for the next
// message. The byte counter wraps modulo 2^61.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_unit
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        message_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      digest_word_o,
  output logic [1:0]       word_index_o,
  output logic             digest_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_SEND
  } state_e;

  state_e       state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  len_q, len_d;
  logic [23:0]  acc_q, acc_d;
  word_t        win_q [NumSched];
  word_t        win_d [NumSched];
  word_t        work_q [NumChain];
  word_t        work_d [NumChain];
  word_t        chain_q [NumChain];
  word_t        chain_d [NumChain];
  logic [5:0]   rnd_q, rnd_d;
  logic         pad_mode_q, pad_mode_d;
  logic         pad_first_q, pad_first_d;
  logic         len_blk_q, len_blk_d;
  logic         out_valid_q, out_valid_d;
  logic [1:0]   idx_q, idx_d;

  logic         push_en;
  logic [7:0]   push_byte;
  logic [7:0]   pad_byte;
  logic [63:0]  len_shift;
  word_t        sched_new;
  word_t        t1, t2;

  // Pick the padding byte: marker, zero fill or the big-endian bit length
  always_comb begin
    len_shift = {len_q, 3'b000} << {fill_q[2:0], 3'b000};
    if (pad_first_q) begin
      pad_byte = PadMarker;
    end else if (len_blk_q && (fill_q >= LenFieldPos)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Shared round unit: schedule extension and one compression round
  always_comb begin
    sched_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    t1 = work_q[7] + big_sigma1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
       + RoundConst[rnd_q] + win_q[0];
    t2 = big_sigma0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);
  end

  // Sequencer and next-state logic
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    acc_d       = acc_q;
    win_d       = win_q;
    work_d      = work_q;
    chain_d     = chain_q;
    rnd_d       = rnd_q;
    pad_mode_d  = pad_mode_q;
    pad_first_d = pad_first_q;
    len_blk_d   = len_blk_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    push_en     = 1'b0;
    push_byte   = pad_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            push_en   = 1'b1;
            push_byte = data_byte_i;
            len_d     = len_q + 61'd1;
          end
          if (message_end_i) begin
            pad_mode_d  = 1'b1;
            pad_first_d = 1'b1;
          end
          if (byte_present_i && (fill_q == 6'd63)) begin
            state_d = ST_COMP;
          end else if (message_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en     = 1'b1;
        pad_first_d = 1'b0;
        if (pad_first_q) begin
          len_blk_d = (fill_q < LenFieldPos);
        end
        if (fill_q == 6'd63) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        rnd_d = rnd_q + 6'd1;
        for (int i = 0; i < NumSched - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[NumSched-1] = sched_new;
        work_d[7] = work_q[6];
        work_d[6] = work_q[5];
        work_d[5] = work_q[4];
        work_d[4] = work_q[3] + t1;
        work_d[3] = work_q[2];
        work_d[2] = work_q[1];
        work_d[1] = work_q[0];
        work_d[0] = t1 + t2;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < NumChain; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (!pad_mode_q) begin
          state_d = ST_IDLE;
        end else if (pad_first_q) begin
          state_d = ST_PAD;
        end else if (len_blk_q) begin
          state_d     = ST_SEND;
          out_valid_d = 1'b1;
          idx_d       = 2'd0;
        end else begin
          len_blk_d = 1'b1;
          state_d   = ST_PAD;
        end
      end
      ST_SEND: begin
        if (out_ready_i) begin
          if (idx_q == 2'd3) begin
            out_valid_d = 1'b0;
            chain_d     = InitHash;
            fill_d      = 6'd0;
            len_d       = 61'd0;
            pad_mode_d  = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Pack bytes into words and push each full word into the window
    if (push_en) begin
      acc_d  = {acc_q[15:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < NumSched - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[NumSched-1] = {acc_q, push_byte};
      end
    end

    // Load the working words when a compression starts
    if ((state_d == ST_COMP) && (state_q != ST_COMP)) begin
      work_d = chain_q;
      rnd_d  = 6'd0;
    end
  end

  // Hold control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= 6'd0;
      len_q       <= 61'd0;
      chain_q     <= InitHash;
      rnd_q       <= 6'd0;
      pad_mode_q  <= 1'b0;
      pad_first_q <= 1'b0;
      len_blk_q   <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      chain_q     <= chain_d;
      rnd_q       <= rnd_d;
      pad_mode_q  <= pad_mode_d;
      pad_first_q <= pad_first_d;
      len_blk_q   <= len_blk_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    win_q  <= win_d;
    work_q <= work_d;
  end

  // Drive the ports
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign word_index_o  = idx_q;
  assign digest_last_o = (idx_q == 2'd3);
  assign digest_word_o = {chain_q[{idx_q, 1'b0}], chain_q[{idx_q, 1'b1}]};

  // Never take a request while a digest word is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

  // An accepted end request drops in_ready_o in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && message_end_i) |=> !in_ready_o)
    else $error("input ready right after end request");

  // Words after a non-final one follow in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !digest_last_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 2'd1)))
    else $error("digest word order broken");

  // The final word ends the digest and reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && digest_last_o) |=> (!out_valid_o && in_ready_o))
    else $error("digest did not end after last word");

endmodule

`default_nettype wire

FILE: dv/sha256_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte requests into the hasher and checks every digest word against
// an in-bench SHA-256 model. A short directed table with known digests runs
// first, followed by random messages sized around the block and padding
// boundaries. Both handshakes stall at random until the final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_test;

  localparam int unsigned RandItems   = 200;
  localparam int unsigned MinMessages = 4;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumDirRows  = 14;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] HashStart [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundKey [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  widx;
    logic        last;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         fin;
    logic         known;
    logic [255:0] digest;
  } dir_row_t;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         in_valid_i     = 1'b0;
  logic         in_ready_o;
  logic [7:0]   data_byte_i    = 8'h00;
  logic         byte_present_i = 1'b0;
  logic         message_end_i  = 1'b0;
  logic         out_valid_o;
  logic         out_ready_i    = 1'b0;
  logic [63:0]  digest_word_o;
  logic [1:0]   word_index_o;
  logic         digest_last_o;

  // Model state of the hasher
  logic [31:0]  chain_h [8];
  logic [7:0]   block_buf [64];
  int unsigned  block_fill;
  logic [60:0]  byte_count;

  digest_beat_t pending_beats [$];
  int unsigned  error_count  = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  stall_left   = 0;
  int unsigned  rand_items   = 0;
  int unsigned  message_count = 0;
  bit           calm         = 1'b0;

  // Directed requests: known digests for the empty message and "abc", plus model-checked short messages
  dir_row_t dir_rows [NumDirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h5a, 1'b0, 1'b1, 1'b1, AbcDigest},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  sha256_stream_hasher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .digest_last_o  (digest_last_o)
  );

  // Toggle the clock
  always #4 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[sha256_stream_hasher_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold the current block into the chaining words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundKey[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = HashStart[i];
    block_fill = 0;
    byte_count = '0;
  endfunction

  // Advance the model by one request and queue the digest words it causes
  function automatic void hash_request(input logic [7:0] data, input logic present,
                                       input logic fin, input logic known,
                                       input logic [255:0] known_digest);
    logic [63:0]  bit_len;
    logic [255:0] digest;
    int unsigned  pos;
    if (present) begin
      block_buf[block_fill] = data;
      block_fill++;
      byte_count = byte_count + 1'b1;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!fin) return;
    // Pad: marker, zero fill, big-endian bit length, spilling into a second block
    bit_len = {byte_count, 3'b000};
    pos = block_fill;
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) block_buf[i] = 8'h00;
      compress_block();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) block_buf[i] = 8'h00;
    for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
              chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    if (known) digest = known_digest;
    for (int k = 0; k < 4; k++) begin
      pending_beats.push_back('{digest[255-64*k -: 64], 2'(k), k == 3});
    end
    restart_hash();
  endfunction

  // Drive one request, hold it until accepted, then update the model
  task automatic send_request(input logic [7:0] data, input logic present, input logic fin,
                              input logic known, input logic [255:0] known_digest);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= data;
    byte_present_i <= present;
    message_end_i  <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    hash_request(data, present, fin, known, known_digest);
    if (present || fin) rand_items++;
    if (fin) message_count++;
  endtask

  // Send a message of the given length with random content and stray no-ops
  task automatic send_message(input int unsigned len);
    bit tail_end;
    tail_end = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      end
      send_request(8'($urandom_range(0, 255)), 1'b1, tail_end && (k == len - 1), 1'b0, '0);
    end
    if (!tail_end) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each accepted digest word against the oldest expectation
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected digest word %h index %0d", digest_word_o, word_index_o);
        error_count++;
      end else begin
        exp_beat = pending_beats.pop_front();
        if (digest_word_o !== exp_beat.word) begin
          $error("digest_word expected %h actual %h", exp_beat.word, digest_word_o);
          error_count++;
        end
        if (word_index_o !== exp_beat.widx) begin
          $error("word_index expected %0d actual %0d", exp_beat.widx, word_index_o);
          error_count++;
        end
        if (digest_last_o !== exp_beat.last) begin
          $error("digest_last expected %0d actual %0d", exp_beat.last, digest_last_o);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned len;
    int unsigned edge_lens [12];
    edge_lens = '{0, 1, 55, 56, 57, 62, 63, 64, 65, 119, 120, 128};
    restart_hash();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int r = 0; r < NumDirRows; r++) begin
      send_request(dir_rows[r].data, dir_rows[r].present, dir_rows[r].fin,
                   dir_rows[r].known, dir_rows[r].digest);
    end

    // Random messages around block and padding boundaries
    rand_items    = 0;
    message_count = 0;
    while (rand_items < RandItems || message_count < MinMessages) begin
      if (rand_items >= RandItems * 4 / 5 && message_count >= MinMessages - 3) calm = 1'b1;
      if ($urandom_range(0, 9) < 4) len = $urandom_range(0, 15);
      else len = edge_lens[$urandom_range(0, 11)];
      send_message(len);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding digest words
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[sha256_stream_hasher_unit] OK");
    end else begin
      $display("[sha256_stream_hasher_unit] ERROR");
    end
    $finish;
  end

endmodule
